[src/crsf_pkg.sv]
// Shared constants, command/status structs and the CRC-8 step for the frame receiver.
package crsf_pkg;

   localparam int MAX_FRAME_BYTES = 64;
   localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
   localparam int LEN_W           = 6;
   localparam int IDX_W           = 6;
   localparam int CSR_IDX_W       = 3;

   localparam logic [7:0] CRC_POLY = 8'hD5;
   localparam logic [7:0] MIN_LEN  = 8'd2;
   localparam logic [7:0] MAX_LEN  = 8'(MAX_FRAME_BYTES - 2);

   // Register indexes on the CSR port.
   localparam logic [CSR_IDX_W-1:0] CSR_RADIO_ADDR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BCAST_ADDR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_BYTE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_START  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIO_ID   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CMD_TYPE   = 3'd5;

   typedef struct packed {
      logic start_cap;
      logic len_cap;
      logic body_wr;
      logic cnt_clr;
      logic cnt_inc;
      logic load_data;
      logic load_err;
   } crsf_cmd_type;

   typedef struct packed {
      logic start_hit;
      logic radio_hit;
      logic len_ok;
      logic body_done;
      logic crc_ok;
      logic drain_last;
      logic err_pending;
   } crsf_status_type;

   // One byte of CRC-8, MSB first.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[src/crsf_dp.sv]
// Datapath: CSR bank, frame buffer memory, byte counter, CRC and output register.
module crsf_dp import crsf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           rx_byte,
   input  crsf_cmd_type         cmd,
   output crsf_status_type      status,
   input  logic                 csr_wr,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data,
   output logic [7:0]           frame_byte,
   output logic [IDX_W-1:0]     byte_index,
   output logic [7:0]           start_value,
   output logic [LEN_W-1:0]     frame_length,
   output logic                 is_extended,
   output logic                 crc_error,
   output logic                 last_of_frame
);

   logic [7:0] radio_addr_ff, bcast_addr_ff, sync_byte_ff;
   logic [7:0] ext_start_ff, radio_id_ff, cmd_type_ff;

   logic [7:0]        mem [MAX_FRAME_BYTES];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0]  len_ff;
   logic [7:0]        start_ff;
   logic [7:0]        type_ff;
   logic [7:0]        crc_ff, crc_in;
   logic              type_ext;

   logic [7:0]       out_byte_ff;
   logic [IDX_W-1:0] out_idx_ff;
   logic             out_ext_ff, out_err_ff, out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radio_addr_ff <= 8'd234;
         bcast_addr_ff <= 8'd0;
         sync_byte_ff  <= 8'd200;
         ext_start_ff  <= 8'd40;
         radio_id_ff   <= 8'd58;
         cmd_type_ff   <= 8'd50;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_RADIO_ADDR: radio_addr_ff <= csr_data;
            CSR_BCAST_ADDR: bcast_addr_ff <= csr_data;
            CSR_SYNC_BYTE:  sync_byte_ff  <= csr_data;
            CSR_EXT_START:  ext_start_ff  <= csr_data;
            CSR_RADIO_ID:   radio_id_ff   <= csr_data;
            CSR_CMD_TYPE:   cmd_type_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   assign status.radio_hit   = (rx_byte == radio_addr_ff);
   assign status.start_hit   = status.radio_hit || (rx_byte == bcast_addr_ff) ||
                               (rx_byte == sync_byte_ff);
   assign status.len_ok      = (rx_byte >= MIN_LEN) && (rx_byte <= MAX_LEN);
   assign status.body_done   = (count_ff == ADDR_W'(len_ff - LEN_W'(1)));
   assign status.crc_ok      = (crc_ff == rx_byte);
   assign status.drain_last  = (count_ff == ADDR_W'(len_ff - LEN_W'(2)));
   assign status.err_pending = out_err_ff;

   assign crc_in = crc8_update(crc_ff, rx_byte);

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.cnt_inc || cmd.body_wr) begin
         count_in = count_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         len_ff   <= '0;
         crc_ff   <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.len_cap) begin
            len_ff <= rx_byte[LEN_W-1:0];
            crc_ff <= '0;
         end else if (cmd.body_wr) begin
            crc_ff <= crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.body_wr) begin
         mem[count_ff] <= rx_byte;
      end
      rd_data_ff <= mem[count_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.start_cap) begin
         start_ff <= rx_byte;
      end
      if (cmd.body_wr && (count_ff == '0)) begin
         type_ff <= rx_byte;
      end
   end

   assign type_ext = !((type_ff < ext_start_ff) || (type_ff == radio_id_ff) ||
                       (type_ff == cmd_type_ff));

   always_ff @(posedge clock) begin
      if (cmd.load_data) begin
         out_byte_ff <= rd_data_ff;
         out_idx_ff  <= IDX_W'(count_ff);
         out_ext_ff  <= type_ext;
         out_err_ff  <= 1'b0;
         out_last_ff <= status.drain_last;
      end else if (cmd.load_err) begin
         out_byte_ff <= '0;
         out_idx_ff  <= '0;
         out_ext_ff  <= 1'b0;
         out_err_ff  <= 1'b1;
         out_last_ff <= 1'b1;
      end
   end

   assign frame_byte    = out_byte_ff;
   assign byte_index    = out_idx_ff;
   assign start_value   = start_ff;
   assign frame_length  = len_ff;
   assign is_extended   = out_ext_ff;
   assign crc_error     = out_err_ff;
   assign last_of_frame = out_last_ff;

endmodule

[src/crsf_ctrl.sv]
// Controller state machine: frame hunting, collection and result drain sequencing.
module crsf_ctrl import crsf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  crsf_status_type status,
   output crsf_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_HUNT, S_LEN, S_BODY, S_READ, S_LOAD, S_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      in_take, out_take;

   assign req_stall = !((state_ff == S_HUNT) || (state_ff == S_LEN) || (state_ff == S_BODY));
   assign rsp_valid = (state_ff == S_WAIT);
   assign in_take   = req_valid && !req_stall;
   assign out_take  = rsp_valid && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_HUNT: begin
            if (in_take && status.start_hit) begin
               cmd.start_cap = 1'b1;
               state_in      = S_LEN;
            end
         end
         S_LEN: begin
            if (in_take) begin
               if (status.len_ok) begin
                  cmd.len_cap = 1'b1;
                  cmd.cnt_clr = 1'b1;
                  state_in    = S_BODY;
               end else if (status.radio_hit) begin
                  cmd.start_cap = 1'b1;
               end else begin
                  state_in = S_HUNT;
               end
            end
         end
         S_BODY: begin
            if (in_take) begin
               if (!status.body_done) begin
                  cmd.body_wr = 1'b1;
               end else if (status.crc_ok) begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = S_READ;
               end else begin
                  cmd.load_err = 1'b1;
                  state_in     = S_WAIT;
               end
            end
         end
         S_READ: state_in = S_LOAD;
         S_LOAD: begin
            cmd.load_data = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (out_take) begin
               if (status.drain_last || status.err_pending) begin
                  state_in = S_HUNT;
               end else begin
                  cmd.cnt_inc = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         default: state_in = S_HUNT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/crsf_frame_receiver.sv]
// Top level of the CRSF-style frame receiver: deframing, CRC-8 check and result drain.
// Flow: a byte is taken every cycle while a frame is collected. After a good CRC byte the first
// result is offered after a memory read and an output load; a CRC error result is offered in the
// next cycle. Each further result is offered after the previous one is taken, again through a
// memory read and an output load, and the input is held off for the whole drain.
// Reset (synchronous, active high) returns to start-byte hunting and loads register defaults.
module crsf_frame_receiver import crsf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // Received byte channel. A transaction completes when req_valid is high and req_stall low.
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   // Result channel. One transaction per type/payload byte, or one for a CRC failure.
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_frame_byte,
   output logic [IDX_W-1:0]     rsp_byte_index,
   output logic [7:0]           rsp_start_value,
   output logic [LEN_W-1:0]     rsp_frame_length,
   output logic                 rsp_is_extended,
   output logic                 rsp_crc_error,
   output logic                 rsp_last_of_frame,
   // Register write channel. Indexes above the last register are ignored.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data
);

   crsf_cmd_type    cmd;
   crsf_status_type status;

   // The register bank is always able to take a write.
   assign csr_ready = 1'b1;

   // The controller sequences the frame: hunt for a start byte, check the length byte,
   // collect the body while the CRC runs, then either drain the buffer or post an error.
   crsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the frame buffer, counters, CRC and the registered result.
   crsf_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .rx_byte       (req_rx_byte),
      .cmd           (cmd),
      .status        (status),
      .csr_wr        (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .frame_byte    (rsp_frame_byte),
      .byte_index    (rsp_byte_index),
      .start_value   (rsp_start_value),
      .frame_length  (rsp_frame_length),
      .is_extended   (rsp_is_extended),
      .crc_error     (rsp_crc_error),
      .last_of_frame (rsp_last_of_frame)
   );

endmodule
